[rtl/core/fcfs_schedule_timing_defines.svh]
// Assertion macros for the first-come-first-served schedule block.
`ifndef FCFS_SCHEDULE_TIMING_DEFINES_SVH
`define FCFS_SCHEDULE_TIMING_DEFINES_SVH

// Same-cycle implication, checked on clk with rst as disable.
`define ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("fcfs same-cycle check failed");

// Next-cycle implication, checked on clk with rst as disable.
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("fcfs next-cycle check failed");

`endif

[rtl/core/fcfs_pkg.sv]
// Shared types and constants of the first-come-first-served schedule block.
package fcfs_pkg;

  localparam int DEF_MAX_PROCS = 16;
  localparam int TIME_W        = 16;
  localparam int CT_W          = 21;
  localparam int SUM_W         = 25;
  localparam int CNT_W         = 5;

  typedef struct packed {
    logic [TIME_W-1:0] process_id;
    logic [TIME_W-1:0] arrival_time;
    logic [TIME_W-1:0] burst_time;
    logic              last_process;
  } proc_t;

  typedef struct packed {
    logic [TIME_W-1:0] out_process_id;
    logic [TIME_W-1:0] out_arrival_time;
    logic [TIME_W-1:0] out_burst_time;
    logic [CT_W-1:0]   completion_time;
    logic [CT_W-1:0]   turnaround_time;
    logic [CT_W-1:0]   waiting_time;
    logic [SUM_W-1:0]  sum_turnaround;
    logic [SUM_W-1:0]  sum_waiting;
    logic [CNT_W-1:0]  process_count;
    logic              table_overflow;
    logic              last_result;
  } sched_t;

  typedef struct packed {
    logic [TIME_W-1:0] id;
    logic [TIME_W-1:0] arr;
    logic [TIME_W-1:0] burst;
  } entry_t;

  // One scheduled process handed from the sequencer to the timeline unit.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [CNT_W-1:0] count;
    logic             ovf;
    entry_t           entry;
  } calc_cmd_t;

  typedef struct packed {
    logic ready;
    logic busy;
  } calc_stat_t;

endpackage

[rtl/core/fcfs_schedule_timing.sv]
// Top level of the first-come-first-served schedule block.
//
// Input channel proc (proc_valid / proc_stall): one process per request, id,
// arrival and burst. Requests are taken one per cycle while loading. The
// request with last_process set ends the batch; requests past MAX_PROCS
// entries are dropped and flag table_overflow on every result of the batch.
// Output channel sched (sched_valid / sched_stall): one result per held
// process, in arrival order (ties in load order), running totals included,
// last_result on the final one.
// For a batch of n processes each result costs one scan of the table through
// its single read port: n reads, the registered read, closing the scan and
// the issue. An issued process then passes through timeline stages a and b
// into the output register.
// A stalled result holds in the output register; the next issue waits until
// that register is free, and loading of the next batch may start meanwhile.
// Reset (rst, synchronous) empties the batch and the output; the table keeps
// its contents, which are only read after being written.
`include "fcfs_schedule_timing_defines.svh"

module fcfs_schedule_timing #(
  parameter int MAX_PROCS = fcfs_pkg::DEF_MAX_PROCS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             proc_valid,
  output logic             proc_stall,
  input  fcfs_pkg::proc_t  proc,
  output logic             sched_valid,
  input  logic             sched_stall,
  output fcfs_pkg::sched_t sched
);

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);

  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  fcfs_pkg::entry_t     mem_wdata;
  logic [IW-1:0]        mem_raddr;
  fcfs_pkg::entry_t     mem_rdata;
  fcfs_pkg::calc_cmd_t  cmd;
  fcfs_pkg::calc_stat_t stat;

  fcfs_mem #(
    .DEPTH (MAX_PROCS),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fcfs_ctrl #(
    .MAX_PROCS (MAX_PROCS),
    .IW        (IW),
    .CW        (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .proc_valid (proc_valid),
    .proc       (proc),
    .proc_stall (proc_stall),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .cmd        (cmd),
    .stat       (stat)
  );

  fcfs_calc u_calc (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .sched_valid (sched_valid),
    .sched_stall (sched_stall),
    .sched       (sched)
  );

  // Table writes only come from accepted requests.
  `ASSERT_IMPL(a_we_on_accept, mem_we, proc_valid && !proc_stall)
  // An issue finds the timeline empty and loading closed.
  `ASSERT_IMPL(a_issue_idle, cmd.valid, !stat.busy && proc_stall)
  // An issued process is in the timeline on the next cycle.
  `ASSERT_NEXT(a_issue_lands, cmd.valid, stat.busy)

endmodule

[rtl/core/fcfs_mem.sv]
// Process table: one write port, one registered read port.
module fcfs_mem #(
  parameter int DEPTH = fcfs_pkg::DEF_MAX_PROCS,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  fcfs_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output fcfs_pkg::entry_t rdata
);

  fcfs_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/fcfs_ctrl.sv]
// Sequencer: loads the table, then scans it once per result for the next process.
module fcfs_ctrl #(
  parameter int MAX_PROCS = fcfs_pkg::DEF_MAX_PROCS,
  parameter int IW        = 4,
  parameter int CW        = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 proc_valid,
  input  fcfs_pkg::proc_t      proc,
  output logic                 proc_stall,
  output logic                 mem_we,
  output logic [IW-1:0]        mem_waddr,
  output fcfs_pkg::entry_t     mem_wdata,
  output logic [IW-1:0]        mem_raddr,
  input  fcfs_pkg::entry_t     mem_rdata,
  output fcfs_pkg::calc_cmd_t  cmd,
  input  fcfs_pkg::calc_stat_t stat
);

  typedef enum logic [1:0] {LOAD, SCAN, EMIT} state_t;

  state_t                      state;
  logic [CW-1:0]               count;
  logic                        ovf;
  logic [CW-1:0]               issue_cnt;
  logic                        rv;
  logic [IW-1:0]               ridx;
  logic                        have_best;
  fcfs_pkg::entry_t            best;
  logic [IW-1:0]               best_idx;
  logic                        have_prev;
  logic [fcfs_pkg::TIME_W-1:0] prev_arr;
  logic [IW-1:0]               prev_idx;
  logic [CW-1:0]               rank;

  logic       accept;
  logic       full;
  logic       after_prev;
  logic       better;
  logic       take;
  logic [6:0] cnt_ext;

  assign proc_stall = (state != LOAD);
  assign accept     = proc_valid && !proc_stall;
  assign full       = (count == CW'(MAX_PROCS));

  assign mem_we    = accept && !full;
  assign mem_waddr = count[IW-1:0];
  assign mem_wdata = '{id: proc.process_id, arr: proc.arrival_time, burst: proc.burst_time};
  assign mem_raddr = issue_cnt[IW-1:0];

  // Next in order is the smallest (arrival, index) strictly past the last one sent.
  assign after_prev = !have_prev || (mem_rdata.arr > prev_arr) ||
                      ((mem_rdata.arr == prev_arr) && (ridx > prev_idx));
  // Strict compare keeps the lowest index among equal arrivals.
  assign better     = !have_best || (mem_rdata.arr < best.arr);
  assign take       = rv && after_prev && better;

  assign cnt_ext   = 7'(count);
  assign cmd.valid = (state == EMIT) && stat.ready;
  assign cmd.last  = (rank == count - CW'(1));
  assign cmd.count = cnt_ext[fcfs_pkg::CNT_W-1:0];
  assign cmd.ovf   = ovf;
  assign cmd.entry = best;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      issue_cnt <= '0;
      rv        <= 1'b0;
      have_best <= 1'b0;
      have_prev <= 1'b0;
      rank      <= '0;
    end else begin
      case (state)
        LOAD: begin
          rv <= 1'b0;
          if (accept) begin
            if (full) begin
              ovf <= 1'b1;
            end else begin
              count <= count + CW'(1);
            end
            if (proc.last_process) begin
              state     <= SCAN;
              issue_cnt <= '0;
              have_best <= 1'b0;
              have_prev <= 1'b0;
              rank      <= '0;
            end
          end
        end
        SCAN: begin
          if (issue_cnt != count) begin
            issue_cnt <= issue_cnt + CW'(1);
            rv        <= 1'b1;
            ridx      <= issue_cnt[IW-1:0];
          end else begin
            rv <= 1'b0;
          end
          if (take) begin
            have_best <= 1'b1;
            best      <= mem_rdata;
            best_idx  <= ridx;
          end
          if ((issue_cnt == count) && !rv) begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (cmd.valid) begin
            have_prev <= 1'b1;
            prev_arr  <= best.arr;
            prev_idx  <= best_idx;
            rank      <= rank + CW'(1);
            if (cmd.last) begin
              state <= LOAD;
              count <= '0;
              ovf   <= 1'b0;
            end else begin
              state     <= SCAN;
              issue_cnt <= '0;
              have_best <= 1'b0;
            end
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

endmodule

[rtl/core/fcfs_calc.sv]
// Timeline unit: clock, completion, turnaround, waiting and running totals.
module fcfs_calc (
  input  logic                 clk,
  input  logic                 rst,
  input  fcfs_pkg::calc_cmd_t  cmd,
  output fcfs_pkg::calc_stat_t stat,
  output logic                 sched_valid,
  input  logic                 sched_stall,
  output fcfs_pkg::sched_t     sched
);

  localparam int CT_W  = fcfs_pkg::CT_W;
  localparam int SUM_W = fcfs_pkg::SUM_W;

  logic                       a_v;
  logic                       a_last;
  logic [fcfs_pkg::CNT_W-1:0] a_count;
  logic                       a_ovf;
  fcfs_pkg::entry_t           a_ent;
  logic [CT_W-1:0]            a_start;

  logic                       b_v;
  logic                       b_last;
  logic [fcfs_pkg::CNT_W-1:0] b_count;
  logic                       b_ovf;
  fcfs_pkg::entry_t           b_ent;
  logic [CT_W-1:0]            b_ct;
  logic [CT_W-1:0]            b_tat;
  logic [CT_W-1:0]            b_wt;

  logic [CT_W-1:0]  clock_time;
  logic [SUM_W-1:0] tot_t;
  logic [SUM_W-1:0] tot_w;

  logic [CT_W-1:0]  cmd_arr;
  logic [CT_W-1:0]  start;
  logic [CT_W-1:0]  a_arr;
  logic [CT_W-1:0]  a_burst;
  logic [CT_W-1:0]  ct;
  logic [SUM_W-1:0] sum_t;
  logic [SUM_W-1:0] sum_w;

  // One process in flight; the output slot must be free or emptying.
  assign stat.ready = !a_v && !b_v && (!sched_valid || !sched_stall);
  assign stat.busy  = a_v || b_v;

  assign cmd_arr = CT_W'(cmd.entry.arr);
  assign start   = (clock_time < cmd_arr) ? cmd_arr : clock_time;

  assign a_arr   = CT_W'(a_ent.arr);
  assign a_burst = CT_W'(a_ent.burst);
  assign ct      = a_start + a_burst;

  assign sum_t = tot_t + SUM_W'(b_tat);
  assign sum_w = tot_w + SUM_W'(b_wt);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v         <= 1'b0;
      b_v         <= 1'b0;
      sched_valid <= 1'b0;
      clock_time  <= '0;
      tot_t       <= '0;
      tot_w       <= '0;
    end else begin
      a_v <= cmd.valid;
      if (cmd.valid) begin
        a_last  <= cmd.last;
        a_count <= cmd.count;
        a_ovf   <= cmd.ovf;
        a_ent   <= cmd.entry;
        a_start <= start;
      end

      b_v <= a_v;
      if (a_v) begin
        b_last     <= a_last;
        b_count    <= a_count;
        b_ovf      <= a_ovf;
        b_ent      <= a_ent;
        b_ct       <= ct;
        b_tat      <= ct - a_arr;
        b_wt       <= a_start - a_arr;
        clock_time <= a_last ? '0 : ct;
      end

      if (b_v) begin
        sched_valid                  <= 1'b1;
        sched.out_process_id         <= b_ent.id;
        sched.out_arrival_time       <= b_ent.arr;
        sched.out_burst_time         <= b_ent.burst;
        sched.completion_time        <= b_ct;
        sched.turnaround_time        <= b_tat;
        sched.waiting_time           <= b_wt;
        sched.sum_turnaround         <= sum_t;
        sched.sum_waiting            <= sum_w;
        sched.process_count          <= b_count;
        sched.table_overflow         <= b_ovf;
        sched.last_result            <= b_last;
        tot_t                        <= b_last ? '0 : sum_t;
        tot_w                        <= b_last ? '0 : sum_w;
      end else if (!sched_stall) begin
        sched_valid <= 1'b0;
      end
    end
  end

endmodule
